// ----- sv/multi_turn_angle_tracker_assert.svh -----
// Assertion macros for the multi-turn angle tracker.
// Needs no package; the including module supplies clock, reset and signals.
`ifndef MULTI_TURN_ANGLE_TRACKER_ASSERT_SVH
`define MULTI_TURN_ANGLE_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTAT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted.
`define MTAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ----- sv/mtat_pkg.sv -----
// Shared types and constants for the multi-turn angle tracker.
// No dependencies; imported by multi_turn_angle_tracker.
`timescale 1ns / 1ps

package mtat_pkg;

    // Field widths fixed by the frame format
    localparam int ANGLE_W  = 16;
    localparam int SPEED_W  = 16;
    localparam int CUR_IN_W = 16;
    localparam int CUR_W    = 14;
    localparam int TOTAL_W  = 37;

    // Input tdata width: angle, speed and raw current
    localparam int S_TDATA_W = ANGLE_W + SPEED_W + CUR_IN_W;

    // Defaults for the top-level parameters
    localparam int COUNTS_PER_TURN_DEF = 8192;
    localparam int TURN_BITS_DEF       = 24;

    // Angle jump that counts as crossing a turn boundary
    localparam int JUMP_THRESH = 4096;

    // Divide by five: multiply by ceil(2^18 / 5) and shift right by 18
    localparam int                  DIV5_SHIFT = 18;
    localparam logic [CUR_IN_W-1:0] DIV5_RECIP = 16'd52429;

    // Frame kind carried on tuser
    typedef enum logic {
        CMD_MEASURE = 1'b0,
        CMD_ZERO    = 1'b1
    } cmd_t;

endpackage

// ----- sv/multi_turn_angle_tracker.sv -----
// Multi-turn angle tracker top level: input register, update logic, result register.
// Depends on mtat_pkg and multi_turn_angle_tracker_assert.svh.
`timescale 1ns / 1ps

// Accepts one decoded feedback frame per clock while results drain, and returns one result
// per frame. A frame is registered at the input, and once the result slot is free the update
// logic (jump compare, turn step, constant multiply for the total, divide by minus five of
// the current) writes the tracker state, which is the result register itself.
// m_tvalid rises once the frame has passed the input register and the result register;
// throughput is one frame per cycle while the result drains every clock,
// set by the single state update per frame in the update stage. While a result
// waits, the input register can still take one frame; once it holds that frame,
// s_tready stays low until the result drains. Result tdata, low bit up:
// angle_now[15:0], speed_now[31:16], current_now[45:32], turns (TURN_BITS),
// total (37 bits), zero padding.
module multi_turn_angle_tracker #(
    parameter int COUNTS_PER_TURN = mtat_pkg::COUNTS_PER_TURN_DEF,
    parameter int TURN_BITS       = mtat_pkg::TURN_BITS_DEF,
    parameter int M_TDATA_W       = ((mtat_pkg::ANGLE_W + mtat_pkg::SPEED_W
                                      + mtat_pkg::CUR_W + TURN_BITS
                                      + mtat_pkg::TOTAL_W + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input frames
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mtat_pkg::S_TDATA_W-1:0] s_tdata,   // angle_word, speed_word, current_word
    input  logic [0:0]                     s_tuser,   // cmd
    // Results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [M_TDATA_W-1:0]           m_tdata    // angle_now, speed_now, current_now,
                                                      // turns, total
);

    import mtat_pkg::*;

    `include "multi_turn_angle_tracker_assert.svh"

    localparam int CPT_W   = $clog2(COUNTS_PER_TURN) + 2;
    localparam int PROD_W  = (TURN_BITS + CPT_W > TOTAL_W) ? TURN_BITS + CPT_W : TOTAL_W;
    localparam int DIFF_W  = ANGLE_W + 2;
    localparam logic signed [DIFF_W-1:0] JUMP_POS = DIFF_W'(JUMP_THRESH);
    localparam logic signed [DIFF_W-1:0] JUMP_NEG = -JUMP_POS;
    localparam logic signed [PROD_W-1:0] CPT_K    = PROD_W'(COUNTS_PER_TURN);

    // Input register
    logic                       in_valid_reg;
    cmd_t                       in_cmd_reg;
    logic signed [ANGLE_W-1:0]  in_angle_reg;
    logic signed [SPEED_W-1:0]  in_speed_reg;
    logic signed [CUR_IN_W-1:0] in_cur_reg;

    // Tracker state, doubling as the result register
    logic                        m_valid_reg;
    logic signed [ANGLE_W-1:0]   angle_reg,   angle_next;
    logic signed [ANGLE_W-1:0]   offset_reg,  offset_next;
    logic signed [TURN_BITS-1:0] turn_reg,    turn_next;
    logic signed [SPEED_W-1:0]   speed_reg,   speed_next;
    logic signed [CUR_W-1:0]     current_reg, current_next;
    logic signed [TOTAL_W-1:0]   total_reg,   total_next;

    logic                        proc_fire;
    logic                        s_fire;
    logic signed [DIFF_W-1:0]    angle_diff;
    logic signed [TURN_BITS-1:0] turn_step;
    logic signed [PROD_W-1:0]    turn_prod;
    logic                        cur_neg;
    logic [CUR_IN_W-1:0]         cur_abs;
    logic [2*CUR_IN_W-1:0]       cur_prod;
    logic [CUR_W-1:0]            cur_quot;
    logic signed [CUR_W-1:0]     current_meas;
    logic signed [TOTAL_W-1:0]   total_meas;

    // Handshake: update when a frame waits and the result slot is free or draining
    assign proc_fire = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_fire    = s_tvalid && s_tready;

    // Capture the incoming transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cmd_reg   <= cmd_t'(s_tuser[0]);
            in_angle_reg <= s_tdata[ANGLE_W-1:0];
            in_speed_reg <= s_tdata[ANGLE_W+SPEED_W-1:ANGLE_W];
            in_cur_reg   <= s_tdata[S_TDATA_W-1:ANGLE_W+SPEED_W];
        end
    end

    // Turn step from the jump between previous and new angle
    always_comb begin
        angle_diff = DIFF_W'(in_angle_reg) - DIFF_W'(angle_reg);
        priority if (angle_diff > JUMP_POS) begin
            turn_step = turn_reg - TURN_BITS'(1);
        end else if (angle_diff < JUMP_NEG) begin
            turn_step = turn_reg + TURN_BITS'(1);
        end else begin
            turn_step = turn_reg;
        end
    end

    // Total angle: turns times counts per turn, plus angle, minus zero offset
    assign turn_prod  = PROD_W'(turn_step) * CPT_K;
    assign total_meas = turn_prod[TOTAL_W-1:0] + TOTAL_W'(in_angle_reg)
                        - TOTAL_W'(offset_reg);

    // Current divided by minus five, truncated toward zero
    assign cur_neg      = in_cur_reg[CUR_IN_W-1];
    assign cur_abs      = cur_neg ? CUR_IN_W'(-in_cur_reg) : CUR_IN_W'(in_cur_reg);
    assign cur_prod     = cur_abs * DIV5_RECIP;
    assign cur_quot     = cur_prod[DIV5_SHIFT+CUR_W-1:DIV5_SHIFT];
    assign current_meas = cur_neg ? $signed(cur_quot) : $signed(-cur_quot);

    // Next state by frame kind
    always_comb begin
        angle_next   = angle_reg;
        offset_next  = offset_reg;
        turn_next    = turn_reg;
        speed_next   = speed_reg;
        current_next = current_reg;
        total_next   = total_reg;
        unique case (in_cmd_reg)
            CMD_MEASURE: begin
                angle_next   = in_angle_reg;
                turn_next    = turn_step;
                speed_next   = in_speed_reg;
                current_next = current_meas;
                total_next   = total_meas;
            end
            CMD_ZERO: begin
                angle_next  = in_angle_reg;
                offset_next = in_angle_reg;
            end
        endcase
    end

    // Advance state and present the result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            angle_reg   <= '0;
            offset_reg  <= '0;
            turn_reg    <= '0;
            speed_reg   <= '0;
            current_reg <= '0;
            total_reg   <= '0;
        end else begin
            if (proc_fire) begin
                m_valid_reg <= 1'b1;
                angle_reg   <= angle_next;
                offset_reg  <= offset_next;
                turn_reg    <= turn_next;
                speed_reg   <= speed_next;
                current_reg <= current_next;
                total_reg   <= total_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({total_reg, turn_reg, current_reg, speed_reg, angle_reg});

    // Checks
    `MTAT_ASSERT_NEXT(a_zero_sets_offset, aclk, aresetn, proc_fire && in_cmd_reg == CMD_ZERO, offset_reg == angle_reg)
    `MTAT_ASSERT_NEXT(a_zero_keeps_total, aclk, aresetn, proc_fire && in_cmd_reg == CMD_ZERO, $stable(total_reg) && $stable(turn_reg))
    `MTAT_ASSERT_NEXT(a_stall_holds_state, aclk, aresetn, m_valid_reg && !m_tready, $stable(angle_reg) && $stable(turn_reg) && $stable(total_reg))
    `MTAT_ASSERT_NEXT(a_turn_single_step, aclk, aresetn, 1'b1, (turn_reg == $past(turn_reg)) || (turn_reg == $past(turn_reg) + TURN_BITS'(1)) || (turn_reg == $past(turn_reg) - TURN_BITS'(1)))
    `MTAT_ASSERT_IMPL(a_full_input_blocks, aclk, aresetn, in_valid_reg && !proc_fire, !s_tready)

endmodule
